>>> design/gra_pkg.sv
// Shared types, constants and helpers for the guillotine rectangle allocator.
`timescale 1ns / 1ps

package gra_pkg;

   localparam int MAX_FREE_RECTS = 64;
   localparam int IDX_W          = $clog2(MAX_FREE_RECTS);
   localparam int CNT_W          = $clog2(MAX_FREE_RECTS + 1);
   localparam int COORD_W        = 11;

   localparam logic       CMD_PLACE      = 1'b0;
   localparam logic       CMD_RELEASE    = 1'b1;
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_TOO_BIG = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic       REG_PAGE_W     = 1'b0;
   localparam logic       REG_PAGE_H     = 1'b1;
   localparam logic [3:0] LOG2_MIN       = 4'd8;
   localparam logic [3:0] LOG2_MAX       = 4'd10;

   typedef struct packed {
      logic        command;
      logic [10:0] req_width;
      logic [10:0] req_height;
   } gra_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] page_number;
      logic [9:0]  pos_x;
      logic [9:0]  pos_y;
      logic [15:0] resource_id;
   } gra_rsp_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
   } gra_entry_type;

   typedef struct packed {
      logic              shift;
      logic              wa_en;
      logic [IDX_W-1:0]  wa_idx;
      gra_entry_type     wa_data;
      logic              wb_en;
      logic [IDX_W-1:0]  wb_idx;
      gra_entry_type     wb_data;
   } gra_cell_ctl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPEND,
      ST_FINISH
   } gra_state_type;

   // Page side in pixels from a log2 register, clamped to the legal range.
   function automatic logic [COORD_W-1:0] side_of(input logic [3:0] lg);
      logic [COORD_W-1:0] side;
      side = 11'd256;
      if (lg >= LOG2_MAX) begin
         side = 11'd1024;
      end else if (lg == 4'd9) begin
         side = 11'd512;
      end
      return side;
   endfunction

endpackage

>>> design/gra_cell.sv
// One cell of the free-list chain: holds one entry, shifts toward the head.
`timescale 1ns / 1ps

module gra_cell (
   input  logic                        clock,
   input  logic [gra_pkg::IDX_W-1:0]   cell_idx,
   input  gra_pkg::gra_cell_ctl_type   ctl,
   input  gra_pkg::gra_entry_type      from_next,
   output gra_pkg::gra_entry_type      entry
);

   gra_pkg::gra_entry_type entry_ff;
   gra_pkg::gra_entry_type entry_in;

   // Direct writes win over the shift.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.wa_en && (ctl.wa_idx == cell_idx)) begin
         entry_in = ctl.wa_data;
      end else if (ctl.wb_en && (ctl.wb_idx == cell_idx)) begin
         entry_in = ctl.wb_data;
      end else if (ctl.shift) begin
         entry_in = from_next;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> design/guillotine_rect_allocator.sv
// Top level: sequencer and chain of free-list cells for the rectangle allocator.
`timescale 1ns / 1ps
// Usage:
// - req_valid/req_stall carry one request word (place or release). A word is
//   taken when req_valid is high and req_stall low.
// - rsp_valid/rsp_stall return exactly one result word per request.
// - csr_valid/csr_ready write page_width_log2 (index 0) or page_height_log2
//   (index 1); csr_ready is always high. Write only while the block is idle.
// - Release and oversize requests go straight to the finish state, and the
//   result is then loaded into the output register. A placement walks the
//   free list once through the cell chain, one entry per cycle, then appends
//   the two remainders; a fit in a full list gives STATUS_FULL instead. With
//   no open page or an empty list it appends to a fresh page at once.
// - The block returns to idle as the result is loaded and takes the next
//   request only then, so it works on one request at a time.
// - If the receiver stalls, the result holds; a following request finishes
//   its work and then waits until the output register frees.
// - Reset empties the free list, closes the page, zeroes the page and id
//   counters and sets both page sizes to 256 pixels. No clearing pass runs.

module guillotine_rect_allocator (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gra_pkg::gra_req_type  req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gra_pkg::gra_rsp_type  rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [3:0]            csr_wdata
);

   localparam int N = gra_pkg::MAX_FREE_RECTS;

   gra_pkg::gra_state_type state_ff, state_in;

   logic [3:0]  pw_log2_ff, ph_log2_ff;
   logic [gra_pkg::CNT_W-1:0] count_ff, count_in;
   logic [gra_pkg::CNT_W-1:0] left_ff, left_in;
   logic        open_ff, open_in;
   logic [15:0] page_ff, page_in;
   logic [15:0] id_ff, id_in;
   logic        found_ff, found_in;
   logic        full_ff, full_in;
   logic        newpage_ff, newpage_in;
   logic [10:0] w_ff, w_in, h_ff, h_in;
   gra_pkg::gra_entry_type s_ff, s_in;
   gra_pkg::gra_rsp_type   res_ff, res_in;
   gra_pkg::gra_rsp_type   rsp_data_ff;
   logic        rsp_valid_ff;

   gra_pkg::gra_cell_ctl_type ctl;
   gra_pkg::gra_entry_type    cells [N];

   logic [10:0] pw, ph;
   logic        accept, too_big, fits, take, found_next, out_free;
   gra_pkg::gra_entry_type head, whole, right_e, bottom_e;

   assign pw        = gra_pkg::side_of(pw_log2_ff);
   assign ph        = gra_pkg::side_of(ph_log2_ff);
   assign req_stall = (state_ff != gra_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign too_big   = (req_data.req_width > pw) || (req_data.req_height > ph);
   assign head      = cells[0];
   assign fits      = (head.w >= w_ff) && (head.h >= h_ff);
   assign take      = fits && !found_ff;
   assign found_next = found_ff || take;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign whole     = '{x: '0, y: '0, w: pw, h: ph};
   assign right_e   = '{x: s_ff.x + w_ff, y: s_ff.y, w: s_ff.w - w_ff, h: s_ff.h};
   assign bottom_e  = '{x: s_ff.x, y: s_ff.y + h_ff, w: w_ff, h: s_ff.h - h_ff};

   // Chain of cells; the last one takes zeros.
   for (genvar i = 0; i < N; i++) begin : g_cell
      gra_pkg::gra_entry_type nxt;
      if (i == N - 1) begin : g_last
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = cells[i+1];
      end
      gra_cell u_cell (
         .clock     (clock),
         .cell_idx  (gra_pkg::IDX_W'(i)),
         .ctl       (ctl),
         .from_next (nxt),
         .entry     (cells[i])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gra_pkg::ST_IDLE: begin
            if (accept) begin
               if ((req_data.command == gra_pkg::CMD_RELEASE) || too_big) begin
                  state_in = gra_pkg::ST_FINISH;
               end else if (open_ff && (count_ff != '0)) begin
                  state_in = gra_pkg::ST_SCAN;
               end else begin
                  state_in = gra_pkg::ST_APPEND;
               end
            end
         end
         gra_pkg::ST_SCAN: begin
            if (left_ff == gra_pkg::CNT_W'(1)) begin
               state_in = (found_next && full_ff) ? gra_pkg::ST_FINISH
                                                  : gra_pkg::ST_APPEND;
            end
         end
         gra_pkg::ST_APPEND: begin
            state_in = gra_pkg::ST_FINISH;
         end
         gra_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = gra_pkg::ST_IDLE;
            end
         end
         default: state_in = gra_pkg::ST_IDLE;
      endcase
   end

   // Datapath and cell control.
   always_comb begin
      count_in   = count_ff;
      left_in    = left_ff;
      open_in    = open_ff;
      page_in    = page_ff;
      id_in      = id_ff;
      found_in   = found_ff;
      full_in    = full_ff;
      newpage_in = newpage_ff;
      w_in       = w_ff;
      h_in       = h_ff;
      s_in       = s_ff;
      res_in     = res_ff;
      ctl        = '0;
      unique case (state_ff)
         gra_pkg::ST_IDLE: begin
            if (accept) begin
               w_in   = req_data.req_width;
               h_in   = req_data.req_height;
               res_in = '0;
               if (req_data.command == gra_pkg::CMD_RELEASE) begin
                  count_in = '0;
                  open_in  = 1'b0;
                  page_in  = '0;
                  id_in    = '0;
               end else if (too_big) begin
                  res_in.status = gra_pkg::STATUS_TOO_BIG;
               end else if (open_ff && (count_ff != '0)) begin
                  left_in    = count_ff;
                  found_in   = 1'b0;
                  full_in    = (count_ff == gra_pkg::CNT_W'(N));
                  newpage_in = 1'b0;
               end else begin
                  newpage_in = 1'b1;
                  s_in       = whole;
               end
            end
         end
         gra_pkg::ST_SCAN: begin
            // Pop the head; drop it if it is the first fit and the list is not full, else requeue at the tail.
            ctl.shift = 1'b1;
            if (take && !full_ff) begin
               count_in = count_ff - gra_pkg::CNT_W'(1);
               s_in     = head;
               found_in = 1'b1;
            end else begin
               ctl.wa_en   = 1'b1;
               ctl.wa_idx  = gra_pkg::IDX_W'(count_ff - gra_pkg::CNT_W'(1));
               ctl.wa_data = head;
               if (take) begin
                  found_in = 1'b1;
               end
            end
            left_in = left_ff - gra_pkg::CNT_W'(1);
            if (left_ff == gra_pkg::CNT_W'(1)) begin
               if (found_next && full_ff) begin
                  res_in        = '0;
                  res_in.status = gra_pkg::STATUS_FULL;
               end else if (!found_next) begin
                  newpage_in = 1'b1;
                  s_in       = whole;
               end
            end
         end
         gra_pkg::ST_APPEND: begin
            // Append right then bottom remainder.
            ctl.wa_en   = 1'b1;
            ctl.wa_data = right_e;
            ctl.wb_en   = 1'b1;
            ctl.wb_data = bottom_e;
            res_in.status = gra_pkg::STATUS_OK;
            res_in.pos_x  = s_ff.x[9:0];
            res_in.pos_y  = s_ff.y[9:0];
            res_in.resource_id = id_ff;
            res_in.page_number = page_ff;
            id_in = id_ff + 16'd1;
            if (newpage_ff) begin
               ctl.wa_idx = '0;
               ctl.wb_idx = gra_pkg::IDX_W'(1);
               count_in   = gra_pkg::CNT_W'(2);
               open_in    = 1'b1;
               if (open_ff) begin
                  page_in            = page_ff + 16'd1;
                  res_in.page_number = page_ff + 16'd1;
               end
            end else begin
               ctl.wa_idx = gra_pkg::IDX_W'(count_ff);
               ctl.wb_idx = gra_pkg::IDX_W'(count_ff + gra_pkg::CNT_W'(1));
               count_in   = count_ff + gra_pkg::CNT_W'(2);
            end
         end
         gra_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gra_pkg::ST_IDLE;
         count_ff     <= '0;
         open_ff      <= 1'b0;
         page_ff      <= '0;
         id_ff        <= '0;
         left_ff      <= '0;
         found_ff     <= 1'b0;
         full_ff      <= 1'b0;
         newpage_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pw_log2_ff   <= gra_pkg::LOG2_MIN;
         ph_log2_ff   <= gra_pkg::LOG2_MIN;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         open_ff    <= open_in;
         page_ff    <= page_in;
         id_ff      <= id_in;
         left_ff    <= left_in;
         found_ff   <= found_in;
         full_ff    <= full_in;
         newpage_ff <= newpage_in;
         if ((state_ff == gra_pkg::ST_FINISH) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            if (csr_index == gra_pkg::REG_PAGE_W) begin
               pw_log2_ff <= csr_wdata;
            end else begin
               ph_log2_ff <= csr_wdata;
            end
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      w_ff   <= w_in;
      h_ff   <= h_in;
      s_ff   <= s_in;
      res_ff <= res_in;
      if ((state_ff == gra_pkg::ST_FINISH) && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= gra_pkg::CNT_W'(N))
      else $error("free count above list depth");

   a_scan_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gra_pkg::ST_SCAN) |-> (open_ff && (left_ff != '0)))
      else $error("scan without open page or entries");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.command == gra_pkg::CMD_RELEASE))
         |=> ((count_ff == '0) && !open_ff && (id_ff == '0)))
      else $error("release left state behind");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gra_pkg::ST_APPEND) |=> (count_ff >= gra_pkg::CNT_W'(2)))
      else $error("append left fewer than two entries");

endmodule
